### hw/rtl/text_console_writer_assert.svh
// Assertion macros shared by the console RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/tcw_pkg.sv
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int ADDR_W  = $clog2(CELLS);

	// biases that make any signed sum non-negative before the modulo
	localparam int COL_BIAS = ((128 + COLUMNS - 1) / COLUMNS) * COLUMNS;
	localparam int ROW_BIAS = ((ROWS + 127 + ROWS - 1) / ROWS) * ROWS;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// config port
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_BASE_ATTR = 1'b0;

	localparam logic [7:0] RESET_COLOR = 8'h02;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;

	// request modes
	localparam logic [2:0] MODE_FMT   = 3'd0;
	localparam logic [2:0] MODE_RAW   = 3'd1;
	localparam logic [2:0] MODE_SET   = 3'd2;
	localparam logic [2:0] MODE_MOVE  = 3'd3;
	localparam logic [2:0] MODE_CLEAR = 3'd4;
	localparam logic [2:0] MODE_READ  = 3'd5;

	// back-end operations
	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_PUT   = 3'd1,
		OP_SET   = 3'd2,
		OP_MOVE  = 3'd3,
		OP_CLEAR = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        resp;       // this command closes its request
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [7:0]  col_arg;    // two's complement
		logic [7:0]  row_arg;    // two's complement
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic init_busy;         // reset clearing pass still running
	} back_status_t;

	// {valid, value} of a hex digit
	function automatic logic [4:0] hex_decode(logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		r = 5'b0;
		d = 8'h00;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + 8'd10;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'd10;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

	// non-negative modulo of a small signed value; v + bias must be below 16*n
	function automatic logic [7:0] wrap_mod(logic [9:0] v, logic [9:0] n, logic [9:0] bias);
		logic [10:0] acc;
		logic [10:0] step;
		acc = {v[9], v} + {1'b0, bias};
		for (int s = 3; s >= 0; s--) begin
			step = {1'b0, n} << s;
			if (acc >= step)
				acc = acc - step;
		end
		return acc[7:0];
	endfunction

endpackage

### hw/rtl/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### hw/rtl/tcw_queue.sv
`include "text_console_writer_assert.svh"

module tcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_cmd,
	output logic          ready,
	input  logic          pop,
	output tcw_pkg::cmd_t head,
	output logic          not_empty
);

	tcw_pkg::cmd_t               slot_q [tcw_pkg::QDEPTH];
	logic [tcw_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [tcw_pkg::QPTR_W:0]    count_q;

	assign ready     = count_q != (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_overflow, clk, arst_n, !ready, !push)
	`ASSERT_IMPLY(a_no_underflow, clk, arst_n, !not_empty, !pop)

endmodule

### hw/rtl/tcw_front.sv
module tcw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [2:0]            mode,
	input  logic [7:0]            ch,
	input  logic signed [7:0]     col_arg,
	input  logic signed [7:0]     row_arg,
	input  logic [10:0]           cell_index,
	input  logic [7:0]            base_attr,
	input  tcw_pkg::back_status_t status,
	input  logic                  q_ready,
	output logic                  push,
	output tcw_pkg::cmd_t         push_cmd
);

	// escape parser states
	typedef enum logic [3:0] {
		P_NORMAL = 4'b0001,
		P_PCT    = 4'b0010,
		P_HASH   = 4'b0100,
		P_TEXT   = 4'b1000
	} parse_t;

	parse_t        ps_q, nxt_ps;
	logic [7:0]    color_q, nxt_color;
	logic [3:0]    txt_q, nxt_txt;
	logic          pend_q;
	tcw_pkg::cmd_t pend_cmd_q;

	logic          accept;
	logic [4:0]    hex;
	logic [7:0]    norm_col;
	logic          use_norm;
	logic          norm_second;
	logic          two;
	tcw_pkg::cmd_t base_cmd, c0, c1, ncmd;

	assign req_ready = !pend_q && q_ready && !status.init_busy;
	assign accept    = req_valid && req_ready;
	assign hex       = tcw_pkg::hex_decode(ch);

	// color a plain character takes when it is handled in normal state
	assign norm_col = (ps_q == P_TEXT) ? {base_attr[7:4], txt_q} : color_q;

	always_comb begin
		base_cmd.op         = tcw_pkg::OP_NOP;
		base_cmd.resp       = 1'b1;
		base_cmd.ch         = ch;
		base_cmd.attr       = color_q;
		base_cmd.col_arg    = col_arg;
		base_cmd.row_arg    = row_arg;
		base_cmd.cell_index = cell_index;
	end

	// classify the request into one or two back-end commands
	always_comb begin
		nxt_ps      = ps_q;
		nxt_color   = color_q;
		nxt_txt     = txt_q;
		c0          = base_cmd;
		c1          = base_cmd;
		two         = 1'b0;
		use_norm    = 1'b0;
		norm_second = 1'b0;
		ncmd        = base_cmd;

		case (mode)
			tcw_pkg::MODE_FMT: begin
				case (ps_q)
					P_PCT: begin
						nxt_ps = P_NORMAL;
						if (ch == tcw_pkg::CH_PCT) begin
							c0.op = tcw_pkg::OP_PUT;
						end else if (ch == tcw_pkg::CH_HASH) begin
							nxt_ps = P_HASH;
						end else begin
							// print the held percent, then treat ch as plain
							c0.op       = tcw_pkg::OP_PUT;
							c0.ch       = tcw_pkg::CH_PCT;
							c0.resp     = 1'b0;
							two         = 1'b1;
							use_norm    = 1'b1;
							norm_second = 1'b1;
						end
					end
					P_HASH: begin
						nxt_ps = P_NORMAL;
						if (ch == tcw_pkg::CH_DOLLAR) begin
							nxt_color = base_attr;
						end else if (hex[4]) begin
							nxt_txt = hex[3:0];
							nxt_ps  = P_TEXT;
						end else begin
							use_norm = 1'b1;
						end
					end
					P_TEXT: begin
						nxt_ps = P_NORMAL;
						if (hex[4]) begin
							nxt_color = {hex[3:0], txt_q};
						end else begin
							nxt_color = {base_attr[7:4], txt_q};
							use_norm  = 1'b1;
						end
					end
					default: begin
						use_norm = 1'b1;
					end
				endcase
			end
			tcw_pkg::MODE_RAW: begin
				c0.op   = tcw_pkg::OP_PUT;
				c0.attr = base_attr;
			end
			tcw_pkg::MODE_SET:   c0.op = tcw_pkg::OP_SET;
			tcw_pkg::MODE_MOVE:  c0.op = tcw_pkg::OP_MOVE;
			tcw_pkg::MODE_CLEAR: c0.op = tcw_pkg::OP_CLEAR;
			tcw_pkg::MODE_READ:  c0.op = tcw_pkg::OP_READ;
			default:             c0.op = tcw_pkg::OP_NOP;
		endcase

		// plain-character handling: NUL resets color, percent opens an escape
		if (use_norm) begin
			ncmd.attr = norm_col;
			if (ch == tcw_pkg::CH_NUL) begin
				nxt_color = base_attr;
				nxt_ps    = P_NORMAL;
			end else if (ch == tcw_pkg::CH_PCT) begin
				nxt_ps = P_PCT;
			end else begin
				ncmd.op = tcw_pkg::OP_PUT;
			end
			if (norm_second)
				c1 = ncmd;
			else
				c0 = ncmd;
		end
	end

	// one command into the queue per cycle while it has room, second one parked in pend
	always_comb begin
		push     = 1'b0;
		push_cmd = c0;
		if (pend_q) begin
			push     = q_ready;
			push_cmd = pend_cmd_q;
		end else if (accept) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && two)
			pend_cmd_q <= c1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q    <= P_NORMAL;
			color_q <= tcw_pkg::RESET_COLOR;
			txt_q   <= 4'h0;
			pend_q  <= 1'b0;
		end else begin
			if (accept) begin
				ps_q    <= nxt_ps;
				color_q <= nxt_color;
				txt_q   <= nxt_txt;
			end
			if (accept && two)
				pend_q <= 1'b1;
			else if (pend_q && q_ready)
				pend_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/tcw_back.sv
`include "text_console_writer_assert.svh"

module tcw_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [7:0]                         base_attr,
	input  logic                               q_valid,
	input  tcw_pkg::cmd_t                      q_head,
	output logic                               pop,
	output tcw_pkg::back_status_t              status,
	output logic                               resp_valid,
	input  logic                               resp_ready,
	output logic [tcw_pkg::ROW_W-1:0]          cursor_row,
	output logic [tcw_pkg::COL_W-1:0]          cursor_col,
	output logic [7:0]                         cell_char,
	output logic [7:0]                         cell_attr
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam int CW = tcw_pkg::COL_W;

	typedef enum logic [2:0] {
		S_SWEEP  = 3'b001,
		S_IDLE   = 3'b010,
		S_RDWAIT = 3'b100
	} state_t;

	state_t          state_q, nxt_state;
	logic [RW-1:0]   row_q, nxt_row;
	logic [CW-1:0]   col_q, nxt_col;
	logic [AW-1:0]   base_q, nxt_base;   // physical cell of logical cell 0
	logic [AW-1:0]   sw_addr_q;
	logic [AW-1:0]   sw_left_q;
	logic [7:0]      sw_attr_q;
	logic            init_q;
	logic            oob_q;

	logic            resp_valid_q;
	logic [RW-1:0]   out_row_q;
	logic [CW-1:0]   out_col_q;
	logic [7:0]      out_char_q;
	logic [7:0]      out_attr_q;

	logic            out_free;
	logic            emit;
	logic            start_sweep;
	logic [AW-1:0]   sweep_from;
	logic [AW-1:0]   sweep_len;
	logic            rd_oob;

	logic [AW-1:0]   lin;
	logic [AW:0]     phys_sum;
	logic [AW-1:0]   phys;
	logic [AW-1:0]   phys_prev;
	logic [AW:0]     idx_sum;
	logic [AW-1:0]   idx_phys;
	logic [AW:0]     base_sum;
	logic [9:0]      row_move, col_move;
	logic [7:0]      row_wrap, col_wrap, row_set, col_set;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [15:0]     ram_wdata;
	logic            ram_re;
	logic [15:0]     ram_rdata;

	// cell store: {attr, char}
	tcw_ram #(
		.WIDTH (16),
		.DEPTH (tcw_pkg::CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_phys),
		.rdata (ram_rdata)
	);

	assign out_free         = !resp_valid_q || resp_ready;
	assign status.init_busy = init_q;

	// cursor to physical cell, rows rotate by base_q
	assign lin      = AW'(AW'(row_q) * AW'(tcw_pkg::COLUMNS)) + AW'(col_q);
	assign phys_sum = {1'b0, lin} + {1'b0, base_q};
	assign phys     = (phys_sum >= (AW + 1)'(tcw_pkg::CELLS)) ?
		AW'(phys_sum - (AW + 1)'(tcw_pkg::CELLS)) : phys_sum[AW-1:0];
	assign phys_prev = (phys == '0) ? AW'(tcw_pkg::CELLS - 1) : phys - 1'b1;

	assign idx_sum  = {1'b0, q_head.cell_index} + {1'b0, base_q};
	assign idx_phys = (idx_sum >= (AW + 1)'(tcw_pkg::CELLS)) ?
		AW'(idx_sum - (AW + 1)'(tcw_pkg::CELLS)) : idx_sum[AW-1:0];
	assign rd_oob   = q_head.cell_index >= AW'(tcw_pkg::CELLS);

	assign base_sum = {1'b0, base_q} + (AW + 1)'(tcw_pkg::COLUMNS);

	// set and move targets
	assign row_move = {5'b00000, row_q} + {{2{q_head.row_arg[7]}}, q_head.row_arg};
	assign col_move = {3'b000, col_q} + {{2{q_head.col_arg[7]}}, q_head.col_arg};
	assign row_wrap = tcw_pkg::wrap_mod(row_move, 10'(tcw_pkg::ROWS), 10'(tcw_pkg::ROW_BIAS));
	assign col_wrap = tcw_pkg::wrap_mod(col_move, 10'(tcw_pkg::COLUMNS),
		10'(tcw_pkg::COL_BIAS));
	assign row_set  = tcw_pkg::wrap_mod({{2{q_head.row_arg[7]}}, q_head.row_arg},
		10'(tcw_pkg::ROWS), 10'(tcw_pkg::ROW_BIAS));
	assign col_set  = tcw_pkg::wrap_mod({{2{q_head.col_arg[7]}}, q_head.col_arg},
		10'(tcw_pkg::COLUMNS), 10'(tcw_pkg::COL_BIAS));

	// command execution
	always_comb begin
		nxt_state   = state_q;
		nxt_row     = row_q;
		nxt_col     = col_q;
		nxt_base    = base_q;
		pop         = 1'b0;
		emit        = 1'b0;
		start_sweep = 1'b0;
		sweep_from  = '0;
		sweep_len   = '0;
		ram_we      = 1'b0;
		ram_waddr   = sw_addr_q;
		ram_wdata   = {sw_attr_q, tcw_pkg::CH_SPACE};
		ram_re      = 1'b0;

		case (state_q)
			S_SWEEP: begin
				ram_we = 1'b1;
				if (sw_left_q == '0)
					nxt_state = S_IDLE;
			end
			S_RDWAIT: begin
				emit      = 1'b1;
				nxt_state = S_IDLE;
			end
			S_IDLE: begin
				if (q_valid && out_free) begin
					case (q_head.op)
						tcw_pkg::OP_PUT: begin
							if (row_q == RW'(tcw_pkg::ROWS)) begin
								// scroll: old top row becomes the blank bottom row,
								// the put retries once it is cleared
								start_sweep = 1'b1;
								sweep_from  = base_q;
								sweep_len   = AW'(tcw_pkg::COLUMNS - 1);
								nxt_base    = (base_sum >= (AW + 1)'(tcw_pkg::CELLS)) ?
									AW'(base_sum - (AW + 1)'(tcw_pkg::CELLS)) :
									base_sum[AW-1:0];
								nxt_row     = RW'(tcw_pkg::ROWS - 1);
								nxt_col     = '0;
								nxt_state   = S_SWEEP;
							end else begin
								pop  = 1'b1;
								emit = q_head.resp;
								if (q_head.ch == tcw_pkg::CH_NL) begin
									nxt_row = row_q + 1'b1;
									nxt_col = '0;
								end else if (q_head.ch == tcw_pkg::CH_BS) begin
									// backspace at the home cell leaves everything alone
									if (row_q != '0 || col_q != '0) begin
										ram_we    = 1'b1;
										ram_waddr = phys_prev;
										ram_wdata = {q_head.attr, tcw_pkg::CH_SPACE};
										if (col_q == '0) begin
											nxt_row = row_q - 1'b1;
											nxt_col = CW'(tcw_pkg::COLUMNS - 1);
										end else begin
											nxt_col = col_q - 1'b1;
										end
									end
								end else begin
									ram_we    = 1'b1;
									ram_waddr = phys;
									ram_wdata = {q_head.attr, q_head.ch};
									if (col_q == CW'(tcw_pkg::COLUMNS - 1)) begin
										nxt_row = row_q + 1'b1;
										nxt_col = '0;
									end else begin
										nxt_col = col_q + 1'b1;
									end
								end
							end
						end
						tcw_pkg::OP_SET: begin
							pop     = 1'b1;
							emit    = q_head.resp;
							nxt_row = row_set[RW-1:0];
							nxt_col = col_set[CW-1:0];
						end
						tcw_pkg::OP_MOVE: begin
							pop     = 1'b1;
							emit    = q_head.resp;
							nxt_row = row_wrap[RW-1:0];
							nxt_col = col_wrap[CW-1:0];
						end
						tcw_pkg::OP_CLEAR: begin
							// cursor result goes out now, the store sweep follows
							pop         = 1'b1;
							emit        = q_head.resp;
							nxt_row     = '0;
							nxt_col     = '0;
							nxt_base    = '0;
							start_sweep = 1'b1;
							sweep_from  = '0;
							sweep_len   = AW'(tcw_pkg::CELLS - 1);
							nxt_state   = S_SWEEP;
						end
						tcw_pkg::OP_READ: begin
							pop       = 1'b1;
							ram_re    = 1'b1;
							nxt_state = S_RDWAIT;
						end
						default: begin
							pop  = 1'b1;
							emit = q_head.resp;
						end
					endcase
				end
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop)
			oob_q <= rd_oob;
		if (emit) begin
			out_row_q <= nxt_row;
			out_col_q <= nxt_col;
			if (state_q == S_RDWAIT && !oob_q) begin
				out_char_q <= ram_rdata[7:0];
				out_attr_q <= ram_rdata[15:8];
			end else begin
				out_char_q <= 8'h00;
				out_attr_q <= 8'h00;
			end
		end
	end

	// control state; reset starts the full clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			row_q        <= '0;
			col_q        <= '0;
			base_q       <= '0;
			sw_addr_q    <= '0;
			sw_left_q    <= AW'(tcw_pkg::CELLS - 1);
			sw_attr_q    <= tcw_pkg::RESET_COLOR;
			init_q       <= 1'b1;
			resp_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			row_q   <= nxt_row;
			col_q   <= nxt_col;
			base_q  <= nxt_base;
			if (start_sweep) begin
				sw_addr_q <= sweep_from;
				sw_left_q <= sweep_len;
				sw_attr_q <= base_attr;
			end else if (state_q == S_SWEEP) begin
				sw_addr_q <= sw_addr_q + 1'b1;
				sw_left_q <= sw_left_q - 1'b1;
			end
			if (state_q == S_SWEEP && sw_left_q == '0)
				init_q <= 1'b0;
			if (emit)
				resp_valid_q <= 1'b1;
			else if (resp_ready)
				resp_valid_q <= 1'b0;
		end
	end

	assign resp_valid = resp_valid_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign cell_char  = out_char_q;
	assign cell_attr  = out_attr_q;

	`ASSERT_IMPLY(a_cursor_range, clk, arst_n, 1'b1,
		(col_q < CW'(tcw_pkg::COLUMNS)) &&
		((row_q < RW'(tcw_pkg::ROWS)) ||
		(row_q == RW'(tcw_pkg::ROWS) && col_q == '0)))
	`ASSERT_IMPLY(a_no_pop_busy, clk, arst_n, state_q != S_IDLE, !pop)
	`ASSERT_NEXT(a_read_answers, clk, arst_n, state_q == S_RDWAIT, resp_valid_q)

endmodule

### hw/rtl/text_console_writer.sv
// Flow: a request goes through the command queue to the back end; a cell read waits
// for the registered store read, and an unknown escape after a percent makes two
// back-end commands. Throughput: one command per cycle in the back end while the
// response channel is free; a read also passes a wait state, a scroll first clears the
// new bottom row (one clear write per cell) and a clear sweeps the whole store.
// Reset: asynchronous, active low; a clearing pass of the whole cell store
// follows, with req_ready low; configuration writes are taken throughout.
module text_console_writer (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,

	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [2:0]                      mode,
	input  logic [7:0]                      ch,
	input  logic signed [7:0]               col_arg,
	input  logic signed [7:0]               row_arg,
	input  logic [10:0]                     cell_index,

	output logic                            resp_valid,
	input  logic                            resp_ready,
	output logic [4:0]                      cursor_row,
	output logic [6:0]                      cursor_col,
	output logic [7:0]                      cell_char,
	output logic [7:0]                      cell_attr
);

	logic                  [7:0] base_attr_q;
	logic                        cfg_wr;
	tcw_pkg::back_status_t       status;
	logic                        q_ready;
	logic                        push;
	tcw_pkg::cmd_t               push_cmd;
	logic                        pop;
	logic                        q_valid;
	tcw_pkg::cmd_t               q_head;

	// config register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == tcw_pkg::REG_BASE_ATTR);
	assign prdata = (paddr[2] == tcw_pkg::REG_BASE_ATTR) ? {24'h0, base_attr_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_attr_q <= tcw_pkg::RESET_COLOR;
		else if (cfg_wr)
			base_attr_q <= pwdata[7:0];
	end

	tcw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.mode          (mode),
		.ch            (ch),
		.col_arg       (col_arg),
		.row_arg       (row_arg),
		.cell_index    (cell_index),
		.base_attr     (base_attr_q),
		.status        (status),
		.q_ready       (q_ready),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.ready     (q_ready),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_valid)
	);

	tcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_attr     (base_attr_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.pop           (pop),
		.status        (status),
		.resp_valid    (resp_valid),
		.resp_ready    (resp_ready),
		.cursor_row    (cursor_row),
		.cursor_col    (cursor_col),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr)
	);

endmodule

### tb/console_checker.sv
// Watches the config port and both request/response channels of the console,
// keeps its own copy of the screen, cursor and escape parser, and compares
// every accepted response with the oldest outstanding expectation.
module console_checker (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	input  logic                            pready,

	input  logic                            req_valid,
	input  logic                            req_ready,
	input  logic [2:0]                      mode,
	input  logic [7:0]                      ch,
	input  logic signed [7:0]               col_arg,
	input  logic signed [7:0]               row_arg,
	input  logic [10:0]                     cell_index,

	input  logic                            resp_valid,
	input  logic                            resp_ready,
	input  logic [4:0]                      cursor_row,
	input  logic [6:0]                      cursor_col,
	input  logic [7:0]                      cell_char,
	input  logic [7:0]                      cell_attr,

	output int                              fail_count,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS   = tcw_pkg::CELLS;
	localparam int COLUMNS = tcw_pkg::COLUMNS;
	localparam int ROWS    = tcw_pkg::ROWS;
	localparam logic [tcw_pkg::CFG_ADDR_W-1:0] BASE_ATTR_ADDR =
		tcw_pkg::CFG_ADDR_W'(4 * tcw_pkg::REG_BASE_ATTR);

	typedef enum logic [3:0] {
		ESC_IDLE    = 4'b0001,
		ESC_PERCENT = 4'b0010,
		ESC_HASH    = 4'b0100,
		ESC_FG_HELD = 4'b1000
	} esc_state_t;

	typedef struct packed {
		logic [4:0] row;
		logic [6:0] col;
		logic [7:0] chr;
		logic [7:0] attr;
	} console_result_t;

	// shadow screen and console state
	logic [7:0]      scr_char [CELLS];
	logic [7:0]      scr_attr [CELLS];
	int              cursor;
	logic [7:0]      cur_color;
	logic [7:0]      base_color;
	esc_state_t      esc;
	logic [3:0]      held_fg;

	console_result_t awaited_results [$];
	int              mismatches = 0;
	int              waiting_count = 0;

	assign fail_count  = mismatches;
	assign outstanding = waiting_count;

	task automatic report_mismatch(input string what);
		$display("%0t console check: %s", $time, what);
		mismatches++;
	endtask

	function automatic int floor_mod(input int v, input int n);
		int r;
		r = v % n;
		if (r < 0)
			r += n;
		return r;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= tcw_pkg::CH_ZERO && c <= tcw_pkg::CH_NINE)
			return int'(c - tcw_pkg::CH_ZERO);
		if (c >= tcw_pkg::CH_LA && c <= tcw_pkg::CH_LF)
			return int'(c - tcw_pkg::CH_LA) + 10;
		if (c >= tcw_pkg::CH_UA && c <= tcw_pkg::CH_UF)
			return int'(c - tcw_pkg::CH_UA) + 10;
		return -1;
	endfunction

	task automatic blank_screen();
		for (int i = 0; i < CELLS; i++) begin
			scr_char[i] = tcw_pkg::CH_SPACE;
			scr_attr[i] = base_color;
		end
	endtask

	// print one byte at the cursor, scrolling first when past the end
	task automatic put_cell(input logic [7:0] c, input logic [7:0] attr);
		int p;
		p = cursor;
		if (p >= CELLS) begin
			p = CELLS - COLUMNS;
			for (int i = 0; i < CELLS - COLUMNS; i++) begin
				scr_char[i] = scr_char[i + COLUMNS];
				scr_attr[i] = scr_attr[i + COLUMNS];
			end
			for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
				scr_char[i] = tcw_pkg::CH_SPACE;
				scr_attr[i] = base_color;
			end
		end
		if (c == tcw_pkg::CH_NL) begin
			p = p + COLUMNS;
			p = p - (p % COLUMNS);
		end else if (c == tcw_pkg::CH_BS) begin
			if (p > 0) begin
				p--;
				scr_char[p] = tcw_pkg::CH_SPACE;
				scr_attr[p] = attr;
			end
		end else begin
			scr_char[p] = c;
			scr_attr[p] = attr;
			p++;
		end
		cursor = p;
	endtask

	task automatic take_plain(input logic [7:0] c);
		if (c == tcw_pkg::CH_NUL) begin
			cur_color = base_color;
			esc = ESC_IDLE;
		end else if (c == tcw_pkg::CH_PCT) begin
			esc = ESC_PERCENT;
		end else begin
			put_cell(c, cur_color);
		end
	endtask

	// escape parser for formatted text
	task automatic take_fmt(input logic [7:0] c);
		int h;
		h = hex_nibble(c);
		case (esc)
			ESC_PERCENT: begin
				esc = ESC_IDLE;
				if (c == tcw_pkg::CH_PCT) begin
					put_cell(tcw_pkg::CH_PCT, cur_color);
				end else if (c == tcw_pkg::CH_HASH) begin
					esc = ESC_HASH;
				end else begin
					put_cell(tcw_pkg::CH_PCT, cur_color);
					take_plain(c);
				end
			end
			ESC_HASH: begin
				esc = ESC_IDLE;
				if (c == tcw_pkg::CH_DOLLAR) begin
					cur_color = base_color;
				end else if (h >= 0) begin
					held_fg = h[3:0];
					esc = ESC_FG_HELD;
				end else begin
					take_plain(c);
				end
			end
			ESC_FG_HELD: begin
				esc = ESC_IDLE;
				if (h >= 0) begin
					cur_color = {h[3:0], held_fg};
				end else begin
					cur_color = {base_color[7:4], held_fg};
					take_plain(c);
				end
			end
			default: take_plain(c);
		endcase
	endtask

	// apply one request and queue the response it must produce
	task automatic apply_request(input logic [2:0] m, input logic [7:0] c,
			input logic signed [7:0] dc, input logic signed [7:0] dr,
			input logic [10:0] idx);
		console_result_t res;
		int r;
		int k;
		res.chr = '0;
		res.attr = '0;
		case (m)
			tcw_pkg::MODE_FMT: take_fmt(c);
			tcw_pkg::MODE_RAW: put_cell(c, base_color);
			tcw_pkg::MODE_SET:
				cursor = floor_mod(int'(dr), ROWS) * COLUMNS +
					floor_mod(int'(dc), COLUMNS);
			tcw_pkg::MODE_MOVE: begin
				r = cursor / COLUMNS + int'(dr);
				k = cursor % COLUMNS + int'(dc);
				cursor = floor_mod(r, ROWS) * COLUMNS + floor_mod(k, COLUMNS);
			end
			tcw_pkg::MODE_CLEAR: begin
				blank_screen();
				cursor = 0;
			end
			tcw_pkg::MODE_READ: begin
				if (int'(idx) < CELLS) begin
					res.chr = scr_char[idx];
					res.attr = scr_attr[idx];
				end
			end
			default: ;
		endcase
		res.row = 5'(cursor / COLUMNS);
		res.col = 7'(cursor % COLUMNS);
		awaited_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_result_t want;
		if (!arst_n) begin
			base_color = tcw_pkg::RESET_COLOR;
			blank_screen();
			cursor = 0;
			cur_color = tcw_pkg::RESET_COLOR;
			esc = ESC_IDLE;
			held_fg = '0;
			awaited_results.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready && paddr == BASE_ATTR_ADDR)
				base_color = pwdata[7:0];
			// responses: compare with the oldest expectation
			if (resp_valid && resp_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = awaited_results.pop_front();
					if (cursor_row !== want.row)
						report_mismatch($sformatf("cursor_row %0d, expected %0d",
							cursor_row, want.row));
					if (cursor_col !== want.col)
						report_mismatch($sformatf("cursor_col %0d, expected %0d",
							cursor_col, want.col));
					if (cell_char !== want.chr)
						report_mismatch($sformatf("cell_char %h, expected %h",
							cell_char, want.chr));
					if (cell_attr !== want.attr)
						report_mismatch($sformatf("cell_attr %h, expected %h",
							cell_attr, want.attr));
				end
			end
			// accepted requests
			if (req_valid && req_ready)
				apply_request(mode, ch, col_arg, row_arg, cell_index);
		end
		waiting_count = awaited_results.size();
	end

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS   = tcw_pkg::CELLS;
	localparam int COLUMNS = tcw_pkg::COLUMNS;
	localparam logic [tcw_pkg::CFG_ADDR_W-1:0] BASE_ATTR_ADDR =
		tcw_pkg::CFG_ADDR_W'(4 * tcw_pkg::REG_BASE_ATTR);
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int PHASE_ITEMS     = 420;
	// a clear walks the whole store after its response
	localparam int CLEAR_SETTLE    = CELLS + 100;
	localparam int TAIL_CYCLES     = 20;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;

	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [tcw_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	logic                           req_valid = 1'b0;
	logic                           req_ready;
	logic [2:0]                     mode = '0;
	logic [7:0]                     ch = '0;
	logic signed [7:0]              col_arg = '0;
	logic signed [7:0]              row_arg = '0;
	logic [10:0]                    cell_index = '0;

	logic                           resp_valid;
	logic                           resp_ready = 1'b0;
	logic [4:0]                     cursor_row;
	logic [6:0]                     cursor_col;
	logic [7:0]                     cell_char;
	logic [7:0]                     cell_attr;

	int                             fail_count;
	int                             outstanding;

	int                             send_idle_pct = 0;
	int                             recv_idle_pct = 0;
	int                             sent = 0;
	int                             cycle_count = 0;

	string                          hex_chars = "0123456789abcdefABCDEF";

	text_console_writer dut (.*);

	console_checker console_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// response backpressure
	always @(negedge clk)
		resp_ready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] rand8();
		return 8'($urandom);
	endfunction

	// present one request from a falling edge and hold it until taken
	task automatic send_req(input logic [2:0] m, input logic [7:0] c,
			input logic [7:0] col, input logic [7:0] row, input logic [10:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid  <= 1'b1;
		mode       <= m;
		ch         <= c;
		col_arg    <= col;
		row_arg    <= row;
		cell_index <= idx;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_fmt(input logic [7:0] c);
		send_req(tcw_pkg::MODE_FMT, c, rand8(), rand8(), 11'($urandom));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_fmt(s[i]);
	endtask

	function automatic logic [7:0] rand_hex();
		return hex_chars[$urandom_range(hex_chars.len() - 1)];
	endfunction

	task automatic write_base_attr(input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BASE_ATTR_ADDR;
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stop requests, let responses and any clear walk finish
	task automatic drain();
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (CLEAR_SETTLE) @(negedge clk);
	endtask

	// a percent escape, mostly well formed
	task automatic send_escape();
		send_fmt(tcw_pkg::CH_PCT);
		case ($urandom_range(9))
			0: send_fmt(tcw_pkg::CH_PCT);
			1: begin
				send_fmt(tcw_pkg::CH_HASH);
				send_fmt(tcw_pkg::CH_DOLLAR);
			end
			2, 3, 4, 5: begin
				send_fmt(tcw_pkg::CH_HASH);
				send_fmt(rand_hex());
				send_fmt(rand_hex());
			end
			6: begin
				send_fmt(tcw_pkg::CH_HASH);
				send_fmt(rand_hex());
				send_fmt(8'($urandom_range(126, 32)));
			end
			7: begin
				send_fmt(tcw_pkg::CH_HASH);
				send_fmt(rand8());
			end
			8: send_fmt(rand8());
			default: begin
				// leave the parser mid-sequence for whatever comes next
				send_fmt(tcw_pkg::CH_HASH);
				send_fmt(rand_hex());
			end
		endcase
	endtask

	task automatic random_request();
		int k;
		int s;
		logic [7:0] c;
		logic [10:0] idx;
		k = $urandom_range(99);
		if (k < 30) begin
			s = $urandom_range(9);
			if (s < 5)
				c = 8'($urandom_range(126, 32));
			else if (s < 7)
				case ($urandom_range(5))
					0: c = tcw_pkg::CH_NL;
					1: c = tcw_pkg::CH_BS;
					2: c = tcw_pkg::CH_NUL;
					3: c = tcw_pkg::CH_PCT;
					4: c = tcw_pkg::CH_HASH;
					default: c = tcw_pkg::CH_DOLLAR;
				endcase
			else
				c = rand8();
			send_fmt(c);
		end else if (k < 50) begin
			send_escape();
		end else if (k < 62) begin
			send_req(tcw_pkg::MODE_RAW, rand8(), rand8(), rand8(), 11'($urandom));
		end else if (k < 70) begin
			// bias toward the bottom row so printing reaches a scroll
			if ($urandom_range(9) < 4)
				send_req(tcw_pkg::MODE_SET, rand8(), 8'($urandom_range(79, 60)),
					$urandom_range(1) ? 8'd24 : 8'hFF, 11'($urandom));
			else
				send_req(tcw_pkg::MODE_SET, rand8(), rand8(), rand8(), 11'($urandom));
		end else if (k < 78) begin
			if ($urandom_range(1))
				send_req(tcw_pkg::MODE_MOVE, rand8(), 8'(int'($urandom_range(6)) - 3),
					8'(int'($urandom_range(6)) - 3), 11'($urandom));
			else
				send_req(tcw_pkg::MODE_MOVE, rand8(), rand8(), rand8(), 11'($urandom));
		end else if (k < 97) begin
			s = $urandom_range(9);
			if (s < 4)
				idx = 11'($urandom);
			else if (s < 7)
				idx = 11'($urandom_range(COLUMNS * 2 - 1));
			else
				idx = 11'($urandom_range(CELLS - 1, CELLS - COLUMNS * 2));
			send_req(tcw_pkg::MODE_READ, rand8(), rand8(), rand8(), idx);
		end else if (k < 98) begin
			send_req(tcw_pkg::MODE_CLEAR, rand8(), rand8(), rand8(), 11'($urandom));
		end else begin
			send_req($urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7,
				rand8(), rand8(), rand8(), 11'($urandom));
		end
	endtask

	task automatic random_phase(input int count);
		int start;
		start = sent;
		while (sent - start < count)
			random_request();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		// the store is cleared after reset; wait until requests are taken
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		write_base_attr(8'h00);
		send_idle_pct = 15;
		recv_idle_pct = 85;

		// reset contents, then text in the reset color
		send_req(tcw_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 11'd0);
		// literal percent, fg+bg, fg then plain char, restore, unknown escapes
		send_text("%%%#fA%#3z%#$%q%#g");
		send_fmt(tcw_pkg::CH_NUL);
		send_fmt(tcw_pkg::CH_NL);
		send_fmt(tcw_pkg::CH_BS);
		// backspace at the home cell does nothing
		send_req(tcw_pkg::MODE_SET, 8'h00, 8'h00, 8'h00, 11'd0);
		send_req(tcw_pkg::MODE_RAW, tcw_pkg::CH_BS, 8'h00, 8'h00, 11'd0);
		send_req(tcw_pkg::MODE_RAW, tcw_pkg::CH_NUL, 8'h00, 8'h00, 11'd0);
		send_req(tcw_pkg::MODE_RAW, 8'hFF, 8'h80, 8'h7F, 11'h7FF);
		// last cell, past the end, then a scroll
		send_req(tcw_pkg::MODE_SET, 8'h00, 8'hFF, 8'hFF, 11'd0);
		send_req(tcw_pkg::MODE_RAW, "Z", 8'h00, 8'h00, 11'd0);
		send_fmt("Y");
		send_req(tcw_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - COLUMNS - 1));
		// relative move from the past-the-end position, negative wrap
		send_req(tcw_pkg::MODE_SET, 8'h00, 8'hFF, 8'hFF, 11'd0);
		send_req(tcw_pkg::MODE_RAW, "W", 8'h00, 8'h00, 11'd0);
		send_req(tcw_pkg::MODE_MOVE, 8'h00, 8'h80, 8'h7F, 11'd0);
		send_req(tcw_pkg::MODE_SET, 8'h00, 8'h80, 8'h80, 11'd0);
		// read beyond the store, unused modes, clear
		send_req(tcw_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 11'h7FF);
		send_req(MODE_SPARE_6, 8'hFF, 8'h7F, 8'h80, 11'h7FF);
		send_req(MODE_SPARE_7, 8'h00, 8'h00, 8'h00, 11'd0);
		send_req(tcw_pkg::MODE_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0);
		send_req(tcw_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 11'(CELLS - 1));

		random_phase(PHASE_ITEMS);

		drain();
		write_base_attr(8'hFF);
		send_idle_pct = 85;
		recv_idle_pct = 15;
		random_phase(PHASE_ITEMS);

		drain();
		write_base_attr(rand8());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(PHASE_ITEMS);

		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
